// ----- rtl/core/mcs_pkg.sv -----
// Shared types and constants of the media container sniffer.
// No dependencies; mcs_classify and media_container_sniffer import this package.
package mcs_pkg;

  localparam int unsigned HEAD_KEEP = 12;
  localparam int unsigned HEAD_IW   = 4;
  localparam int unsigned WIN_DEPTH = 3;

  localparam logic [7:0] SYNC_BYTE = 8'h47;

  localparam logic [31:0] EBML_MAGIC = 32'h1A45DFA3;
  localparam logic [31:0] TAG_FTYP   = "ftyp";
  localparam logic [31:0] TAG_RIFF   = "RIFF";
  localparam logic [31:0] TAG_AVI    = "AVI ";
  localparam logic [31:0] BRAND_QT   = "qt  ";
  localparam logic [31:0] BRAND_AVIF = "avif";
  localparam logic [31:0] BRAND_AVIS = "avis";
  localparam logic [31:0] BRAND_HEIC = "heic";
  localparam logic [31:0] BRAND_HEIX = "heix";
  localparam logic [31:0] BRAND_MIF1 = "mif1";
  localparam logic [31:0] BRAND_MSF1 = "msf1";

  localparam logic [7:0] CHR_W = "w";
  localparam logic [7:0] CHR_E = "e";
  localparam logic [7:0] CHR_B = "b";
  localparam logic [7:0] CHR_M = "m";

  typedef enum logic [2:0] {
    KIND_UNKNOWN   = 3'd0,
    KIND_MP4       = 3'd1,
    KIND_QUICKTIME = 3'd2,
    KIND_MATROSKA  = 3'd3,
    KIND_WEBM      = 3'd4,
    KIND_AVI       = 3'd5,
    KIND_MPEG_TS   = 3'd6
  } container_kind_e;

  // First bytes of the head, byte 0 at index 0.
  typedef logic [HEAD_KEEP-1:0][7:0] head_t;

  // Per-head evidence gathered while the bytes stream in.
  typedef struct packed {
    logic long_enough;
    logic webm_seen;
    logic ts_cadence;
  } evidence_t;

  // Four head bytes starting at a fixed offset, first byte in the top bits.
  function automatic logic [31:0] head_word(head_t head, int unsigned at);
    return {head[at], head[at+1], head[at+2], head[at+3]};
  endfunction

endpackage

// ----- rtl/core/mcs_if.sv -----
// Valid/ready channel interfaces of the media container sniffer.
// No dependencies; the payload widths match the fields used in mcs_pkg.
interface mcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mcs_kind_if;
  logic       valid;
  logic       ready;
  logic [2:0] container_kind;

  modport source (output valid, output container_kind, input ready);
  modport sink (input valid, input container_kind, output ready);
endinterface

// ----- rtl/core/mcs_classify.sv -----
// Container decision from the stored head bytes and the gathered evidence.
// Purely combinational; depends on mcs_pkg.
module mcs_classify (
  input  mcs_pkg::head_t           head_i,
  input  mcs_pkg::evidence_t       evid_i,
  output mcs_pkg::container_kind_e kind_o
);
  import mcs_pkg::*;

  logic [31:0] brand;
  logic        is_iso;
  logic        still_image;
  logic        is_ebml;
  logic        is_avi;

  assign brand       = head_word(head_i, 8);
  assign is_iso      = head_word(head_i, 4) == TAG_FTYP;
  assign still_image = (brand == BRAND_AVIF) || (brand == BRAND_AVIS) ||
                       (brand == BRAND_HEIC) || (brand == BRAND_HEIX) ||
                       (brand == BRAND_MIF1) || (brand == BRAND_MSF1);
  assign is_ebml     = head_word(head_i, 0) == EBML_MAGIC;
  assign is_avi      = (head_word(head_i, 0) == TAG_RIFF) && (brand == TAG_AVI);

  // Priority order: ISO media, EBML, RIFF/AVI, transport stream cadence.
  // Still-image ISO brands fall through to the later checks.
  always_comb begin
    kind_o = KIND_UNKNOWN;
    if (!evid_i.long_enough) begin
      kind_o = KIND_UNKNOWN;
    end else if (is_iso && brand == BRAND_QT) begin
      kind_o = KIND_QUICKTIME;
    end else if (is_iso && !still_image) begin
      kind_o = KIND_MP4;
    end else if (is_ebml) begin
      kind_o = evid_i.webm_seen ? KIND_WEBM : KIND_MATROSKA;
    end else if (is_avi) begin
      kind_o = KIND_AVI;
    end else if (evid_i.ts_cadence) begin
      kind_o = KIND_MPEG_TS;
    end
  end

endmodule

// ----- rtl/core/media_container_sniffer.sv -----
// Media container sniffer: classifies a file head streamed one word per cycle.
// The result register loads when the update stage takes the final word.
// Throughput: one word per cycle; a final word waits on an untaken result.
// Reset (rst_ni low, asynchronous) empties both stages and clears the state.
// After each final word the per-head state returns to its reset value.
// Depends on mcs_pkg, mcs_if.sv and mcs_classify.
module media_container_sniffer #(
  parameter int unsigned SEARCH_LIMIT  = 256,
  parameter int unsigned PACKET_LENGTH = 188
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcs_byte_if.sink          byte_i,
  mcs_kind_if.source        kind_o
);
  import mcs_pkg::*;

  localparam int unsigned POS_W   = $clog2(SEARCH_LIMIT + 1);
  localparam int unsigned PHASE_W = $clog2(PACKET_LENGTH);

  // Input register: the accepted word waits here for the update stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Per-head state.
  logic [POS_W-1:0]               pos_q, pos_d;
  logic [WIN_DEPTH-1:0][7:0]      win_q, win_d;
  head_t                          head_q, head_d;
  logic                           webm_q, webm_d;
  logic [PHASE_W-1:0]             phase_q, phase_d;
  logic                           intact_q, intact_d;
  logic [1:0]                     rep_q, rep_d;

  // Result register.
  logic            out_valid_q;
  container_kind_e kind_q;

  logic            step;
  logic            in_search;
  logic            webm_hit;
  evidence_t       evid;
  container_kind_e kind_new;

  // The update stage advances unless it holds a final word and the result
  // register is still occupied by an untaken result. Words that are not
  // final never wait for the output side.
  assign step = in_valid_q && (!in_last_q || !out_valid_q || kind_o.ready);
  assign byte_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_last_q  <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
      in_last_q  <= byte_i.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  // Next state for one word. The decision looks at the state as it stands
  // after the final word has been folded in.
  assign in_search = pos_q < POS_W'(SEARCH_LIMIT);
  assign webm_hit  = in_search && (pos_q >= POS_W'(3)) &&
                     in_byte_q == CHR_M && win_q[0] == CHR_B &&
                     win_q[1] == CHR_E && win_q[2] == CHR_W;

  always_comb begin
    head_d = head_q;
    if (pos_q < POS_W'(HEAD_KEEP)) begin
      head_d[pos_q[HEAD_IW-1:0]] = in_byte_q;
    end

    webm_d = webm_q || webm_hit;
    pos_d  = in_search ? pos_q + POS_W'(1) : pos_q;

    // Sync bytes are checked at every packet boundary, the first one included;
    // only those after byte zero count toward the repeat total.
    intact_d = intact_q;
    rep_d    = rep_q;
    if (phase_q == '0) begin
      if (in_byte_q != SYNC_BYTE) begin
        intact_d = 1'b0;
      end else if (pos_q != '0 && rep_q < 2'd2) begin
        rep_d = rep_q + 2'd1;
      end
    end
    phase_d = (phase_q == PHASE_W'(PACKET_LENGTH - 1)) ? '0 : phase_q + PHASE_W'(1);

    win_d[0] = in_byte_q;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign evid.long_enough = pos_d >= POS_W'(HEAD_KEEP);
  assign evid.webm_seen   = webm_d;
  assign evid.ts_cadence  = intact_d && (rep_d == 2'd2);

  mcs_classify u_classify (
    .head_i (head_d),
    .evid_i (evid),
    .kind_o (kind_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      win_q    <= '0;
      head_q   <= '0;
      webm_q   <= 1'b0;
      phase_q  <= '0;
      intact_q <= 1'b1;
      rep_q    <= 2'd0;
    end else if (step) begin
      if (in_last_q) begin
        // A finished head leaves the block ready for the next one.
        pos_q    <= '0;
        win_q    <= '0;
        head_q   <= '0;
        webm_q   <= 1'b0;
        phase_q  <= '0;
        intact_q <= 1'b1;
        rep_q    <= 2'd0;
      end else begin
        pos_q    <= pos_d;
        win_q    <= win_d;
        head_q   <= head_d;
        webm_q   <= webm_d;
        phase_q  <= phase_d;
        intact_q <= intact_d;
        rep_q    <= rep_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (kind_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      kind_q <= kind_new;
    end
  end

  assign kind_o.valid          = out_valid_q;
  assign kind_o.container_kind = kind_q;

  // A final word always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> out_valid_q)
    else $error("final word did not load the result register");

  // After a final word the per-head state starts over.
  a_state_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> pos_q == '0 && intact_q && rep_q == 2'd0 && !webm_q)
    else $error("per-head state not cleared after final word");

  // The sync repeat count saturates at two.
  a_rep_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q != 2'd3)
    else $error("sync repeat count overflowed");

  // A word held back in the input register stays put until it advances.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("stalled input word was lost or changed");

endmodule
